[src/ps2hcq_pkg.sv]
// shared types and constants of the ps2 host command queue
package ps2hcq_pkg;

	localparam int FIFO_AW     = 8;
	localparam int FIFO_DEPTH  = 1 << FIFO_AW;
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] BYTE_ACK    = 8'hFA;
	localparam logic [7:0] BYTE_RESEND = 8'hFE;
	localparam logic [7:0] BYTE_BAT    = 8'hAA;
	localparam logic [7:0] CMD_RESET   = 8'hFF;

	localparam logic [3:0] RETRY_MAX     = 4'd15;
	localparam logic [3:0] SEND_CAP_INIT = 4'd3;

	localparam logic [0:0] REG_SEND_CAP = 1'b0;

	typedef enum logic [1:0] {
		FUNC_RX   = 2'd0,
		FUNC_ENQ  = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT_ACK,
		PH_WAIT_BAT
	} phase_t;

	typedef struct packed {
		logic [7:0] code;
		logic       with_data;
		logic [7:0] data;
		logic [3:0] retries;
	} cmd_entry_t;

endpackage

[src/ps2_host_command_queue.sv]
// ps2 host command queue with resend handling and scan code fifo
//
// Each input word is taken into an input register and handled once the result register
// is free; the transmit bytes and the status it causes are loaded into the result register and
// leave on the master side one word per cycle while m_axis_tready is high, transmit bytes
// first, then a status word with tlast set. An input word gives one to three result words,
// so the sustained pace is set by the result stream; a new input word is taken while the
// previous results are still being delivered. Between input accept and the first result
// word lie the input register and the result register. The scan code fifo is a 256 x 8
// memory with a registered read port and needs no clearing pass.
module ps2_host_command_queue
	import ps2hcq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// rx_byte[7:0], cmd_code[15:8], cmd_has_data[16], cmd_data[24:17]
	input  logic [31:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// out_byte[7:0], scan_valid[8], cmd_done[9], cmd_failed[10], enqueue_dropped[11]
	output logic [15:0] m_axis_tdata,
	// kind[0]
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [3:0] send_cap_q;

	logic       valid_s1;
	func_t      func_s1;
	logic [7:0] rx_s1;
	logic [7:0] code_s1;
	logic       has_s1;
	logic [7:0] data_s1;

	logic       valid_s2;
	logic [1:0] idx_s2;
	logic [1:0] ntx_s2;
	logic [7:0] tx0_s2;
	logic [7:0] tx1_s2;
	logic       sv_s2;
	logic       done_s2;
	logic       fail_s2;
	logic       drop_s2;
	logic [7:0] rd_data_s2;

	cmd_entry_t            queue_q [QUEUE_DEPTH];
	logic [QUEUE_CW-1:0]   count_q;
	phase_t                phase_q;
	phase_t                phase_d;
	logic [FIFO_AW-1:0]    rd_ptr_q;
	logic [FIFO_AW-1:0]    wr_ptr_q;
	logic [7:0]            scan_mem [FIFO_DEPTH];

	logic in_fire, out_fire, out_last, s2_free, advance;
	logic handled, retire, retry_wr, enq, push, pop, fifo_full;
	logic [3:0] retry_new;
	logic [1:0] ntx;
	logic [7:0] tx0, tx1;
	logic sv, done, fail, drop;
	cmd_entry_t head, nxt;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SEND_CAP) ? {28'd0, send_cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_cap_q <= SEND_CAP_INIT;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SEND_CAP) begin
			send_cap_q <= pwdata[3:0];
		end
	end

	// handshake
	assign out_last      = (idx_s2 == ntx_s2);
	assign out_fire      = valid_s2 && m_axis_tready;
	assign s2_free       = !valid_s2 || (out_fire && out_last);
	assign advance       = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1 <= func_t'(s_axis_tuser);
			rx_s1   <= s_axis_tdata[7:0];
			code_s1 <= s_axis_tdata[15:8];
			has_s1  <= s_axis_tdata[16];
			data_s1 <= s_axis_tdata[24:17];
		end
	end

	// command handling
	assign head      = queue_q[0];
	assign nxt       = queue_q[1];
	assign fifo_full = (FIFO_AW'(wr_ptr_q + 1'b1) == rd_ptr_q);
	assign retry_new = (head.retries != RETRY_MAX) ? head.retries + 4'd1 : head.retries;

	always_comb begin
		phase_d  = phase_q;
		handled  = 1'b0;
		retire   = 1'b0;
		retry_wr = 1'b0;
		enq      = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		ntx      = 2'd0;
		tx0      = 8'd0;
		tx1      = 8'd0;
		sv       = 1'b0;
		done     = 1'b0;
		fail     = 1'b0;
		drop     = 1'b0;
		unique case (func_s1)
			FUNC_RX: begin
				if (phase_q == PH_WAIT_ACK && count_q != '0) begin
					if (rx_s1 == BYTE_ACK) begin
						handled = 1'b1;
						if (head.code == CMD_RESET) begin
							phase_d = PH_WAIT_BAT;
						end else begin
							done   = 1'b1;
							retire = 1'b1;
						end
					end else if (rx_s1 == BYTE_RESEND) begin
						handled  = 1'b1;
						retry_wr = 1'b1;
						if (retry_new < send_cap_q) begin
							ntx = head.with_data ? 2'd2 : 2'd1;
							tx0 = head.code;
							tx1 = head.data;
						end else begin
							fail   = 1'b1;
							retire = 1'b1;
						end
					end
				end else if (phase_q == PH_WAIT_BAT && count_q != '0 && rx_s1 == BYTE_BAT) begin
					handled = 1'b1;
					done    = 1'b1;
					retire  = 1'b1;
				end
				if (retire) begin
					if (count_q == QUEUE_CW'(1)) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_WAIT_ACK;
						ntx     = nxt.with_data ? 2'd2 : 2'd1;
						tx0     = nxt.code;
						tx1     = nxt.data;
					end
				end
				push = !handled && rx_s1 != BYTE_ACK && rx_s1 != BYTE_RESEND &&
					rx_s1 != BYTE_BAT && !fifo_full;
			end
			FUNC_ENQ: begin
				if (count_q == QUEUE_CW'(QUEUE_DEPTH)) begin
					drop = 1'b1;
				end else begin
					enq = 1'b1;
					if (phase_q == PH_IDLE) begin
						phase_d = PH_WAIT_ACK;
						ntx     = has_s1 ? 2'd2 : 2'd1;
						tx0     = code_s1;
						tx1     = data_s1;
					end
				end
			end
			FUNC_READ: begin
				if (rd_ptr_q != wr_ptr_q) begin
					pop = 1'b1;
					sv  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else if (advance) begin
			if (enq) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (retire) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
			if (push) begin
				wr_ptr_q <= FIFO_AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= FIFO_AW'(rd_ptr_q + 1'b1);
			end
		end
	end

	// command queue, head at entry 0
	always_ff @(posedge clk) begin
		if (advance) begin
			if (retire) begin
				for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
					queue_q[i] <= queue_q[i + 1];
				end
			end else if (retry_wr) begin
				queue_q[0].retries <= retry_new;
			end
			if (enq) begin
				queue_q[count_q[QUEUE_AW-1:0]] <= '{code: code_s1, with_data: has_s1,
					data: data_s1, retries: 4'd0};
			end
		end
	end

	// scan code memory
	always_ff @(posedge clk) begin
		if (advance && push) begin
			scan_mem[wr_ptr_q] <= rx_s1;
		end
		if (advance) begin
			rd_data_s2 <= scan_mem[rd_ptr_q];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 2'd0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			idx_s2   <= 2'd0;
		end else if (out_fire) begin
			if (out_last) begin
				valid_s2 <= 1'b0;
				idx_s2   <= 2'd0;
			end else begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ntx_s2  <= ntx;
			tx0_s2  <= tx0;
			tx1_s2  <= tx1;
			sv_s2   <= sv;
			done_s2 <= done;
			fail_s2 <= fail;
			drop_s2 <= drop;
		end
	end

	// output word
	always_comb begin
		m_axis_tdata = 16'd0;
		if (out_last) begin
			m_axis_tdata[7:0] = sv_s2 ? rd_data_s2 : 8'd0;
			m_axis_tdata[8]   = sv_s2;
			m_axis_tdata[9]   = done_s2;
			m_axis_tdata[10]  = fail_s2;
			m_axis_tdata[11]  = drop_s2;
		end else begin
			m_axis_tdata[7:0] = (idx_s2 == 2'd0) ? tx0_s2 : tx1_s2;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = out_last;
	assign m_axis_tlast  = out_last;

endmodule
